/* rtl/core/stock_span_monotonic_stack_top_macros.svh */
// Assertion macros shared by the stock span block.
`ifndef STOCK_SPAN_MONOTONIC_STACK_TOP_MACROS_SVH
`define STOCK_SPAN_MONOTONIC_STACK_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while in reset
`define SSMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stock span assertion failed");

// Next-cycle implication, disabled while in reset
`define SSMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stock span assertion failed");

`else

`define SSMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/core/ssms_pkg.sv */
package ssms_pkg;

	typedef struct packed {
		logic valid;
		logic first;
	} ssms_item_ctrl_t;

endpackage

/* rtl/core/ssms_front.sv */
module ssms_front import ssms_pkg::*; #(
	parameter int HEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_first,
	input  logic [HEIGHT_BITS-1:0] in_height,
	output ssms_item_ctrl_t        q_ctrl,
	output logic [HEIGHT_BITS-1:0] q_height,
	input  logic                   q_ready
);

	localparam logic [1:0] FILL_FULL = 2'd2;

	logic                   ent_first_q  [2];
	logic [HEIGHT_BITS-1:0] ent_height_q [2];
	logic                   wr_ptr_q;
	logic                   rd_ptr_q;
	logic [1:0]             fill_q;
	logic                   wr;
	logic                   rd;

	assign in_ready = (fill_q != FILL_FULL);
	assign wr       = in_valid && in_ready;
	assign rd       = q_ctrl.valid && q_ready;

	always_comb begin
		q_ctrl.valid = (fill_q != 2'd0);
		q_ctrl.first = ent_first_q[rd_ptr_q];
		q_height     = ent_height_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_first_q[wr_ptr_q]  <= in_first;
			ent_height_q[wr_ptr_q] <= in_height;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(wr) - 2'(rd);
		end
	end

endmodule

/* rtl/core/ssms_back.sv */
`include "stock_span_monotonic_stack_top_macros.svh"

module ssms_back import ssms_pkg::*; #(
	parameter int STACK_DEPTH = 256,
	parameter int HEIGHT_BITS = 16,
	parameter int SPAN_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ssms_item_ctrl_t        q_ctrl,
	input  logic [HEIGHT_BITS-1:0] q_height,
	output logic                   q_ready,
	output logic                   m_valid,
	input  logic                   m_ready,
	output logic [SPAN_BITS-1:0]   m_span,
	output logic                   m_overflow
);

	localparam int                  PTR_BITS   = $clog2(STACK_DEPTH);
	localparam logic [PTR_BITS-1:0] PTR_LAST   = PTR_BITS'(STACK_DEPTH - 1);
	localparam int                  CNT_BITS   = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL   = CNT_BITS'(STACK_DEPTH);
	localparam int                  ENTRY_BITS = HEIGHT_BITS + SPAN_BITS;

	typedef enum logic {
		ST_TAKE,
		ST_CMP
	} state_t;

	function automatic logic [PTR_BITS-1:0] ptr_dec(input logic [PTR_BITS-1:0] p);
		return (p == '0) ? PTR_LAST : p - 1'b1;
	endfunction

	function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	logic [ENTRY_BITS-1:0]  mem [STACK_DEPTH];
	logic [ENTRY_BITS-1:0]  rd_q;

	state_t                 state_q;
	logic [PTR_BITS-1:0]    top_q;
	logic [CNT_BITS-1:0]    count_q;
	logic                   ovf_q;
	logic [HEIGHT_BITS-1:0] h_q;
	logic [SPAN_BITS-1:0]   span_q;
	logic                   m_valid_q;
	logic [SPAN_BITS-1:0]   m_span_q;
	logic                   m_ovf_q;

	logic [PTR_BITS-1:0]    top_m1;
	logic [PTR_BITS-1:0]    top_m2;
	logic [PTR_BITS-1:0]    top_p1;
	logic [HEIGHT_BITS-1:0] rd_h;
	logic [SPAN_BITS-1:0]   rd_s;
	logic [SPAN_BITS:0]     sum;
	logic [SPAN_BITS-1:0]   span_add;
	logic                   take;
	logic                   pop;
	logic                   push;
	logic                   out_free;
	logic                   full;
	logic                   rd_en;
	logic [PTR_BITS-1:0]    rd_addr;

	always_comb begin
		top_m1   = ptr_dec(top_q);
		top_m2   = ptr_dec(top_m1);
		top_p1   = ptr_inc(top_q);
		rd_h     = rd_q[ENTRY_BITS-1:SPAN_BITS];
		rd_s     = rd_q[SPAN_BITS-1:0];
		sum      = {1'b0, span_q} + {1'b0, rd_s};
		span_add = sum[SPAN_BITS] ? '1 : sum[SPAN_BITS-1:0];
		take     = (state_q == ST_TAKE) && q_ctrl.valid;
		pop      = (state_q == ST_CMP) && (count_q != '0) && (rd_h <= h_q);
		out_free = !m_valid_q || m_ready;
		push     = (state_q == ST_CMP) && !pop && out_free;
		full     = (count_q == CNT_FULL);
		rd_en    = take || pop;
		rd_addr  = take ? top_m1 : top_m2;
	end

	assign q_ready    = (state_q == ST_TAKE);
	assign m_valid    = m_valid_q;
	assign m_span     = m_span_q;
	assign m_overflow = m_ovf_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[top_q] <= {h_q, span_q};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_TAKE;
			top_q     <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			h_q       <= '0;
			span_q    <= '0;
			m_valid_q <= 1'b0;
			m_span_q  <= '0;
			m_ovf_q   <= 1'b0;
		end else begin
			if (m_valid_q && m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_TAKE: begin
					if (q_ctrl.valid) begin
						h_q     <= q_height;
						span_q  <= SPAN_BITS'(1);
						state_q <= ST_CMP;
						if (q_ctrl.first) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end
					end
				end
				ST_CMP: begin
					if (pop) begin
						span_q  <= span_add;
						top_q   <= top_m1;
						count_q <= count_q - 1'b1;
					end else if (out_free) begin
						// full stack: the new entry overwrites the oldest slot
						top_q <= top_p1;
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						m_valid_q <= 1'b1;
						m_span_q  <= span_q;
						m_ovf_q   <= ovf_q || full;
						state_q   <= ST_TAKE;
					end
				end
				default: begin
					state_q <= ST_TAKE;
				end
			endcase
		end
	end

	`SSMS_ASSERT_NXT(a_pop_shrinks, clk, arst_n, pop, count_q == $past(count_q) - 1'b1)
	`SSMS_ASSERT_NXT(a_push_delivers, clk, arst_n, push, m_valid_q && (state_q == ST_TAKE))
	`SSMS_ASSERT_IMP(a_span_nonzero, clk, arst_n, push, span_q != '0)
	`SSMS_ASSERT_NXT(a_full_flags, clk, arst_n, push && full, ovf_q && (count_q == CNT_FULL))
	`SSMS_ASSERT_NXT(a_first_clears, clk, arst_n, take && q_ctrl.first,
		(count_q == '0) && !ovf_q)

endmodule

/* rtl/core/stock_span_monotonic_stack_top.sv */
// Stock span engine: for each height received on the slave stream the block returns the
// span, one plus the run of directly preceding heights in the row that are not taller,
// saturating at the all-ones value, together with a sticky overflow flag for the row.
// An item with the first flag set starts a new row. The stack lives in a single-port
// memory of STACK_DEPTH entries with a registered read. In the stack engine an item
// first reads the top of stack; each compare step checks one entry, a pop fetches the
// next, and the first step that does not pop pushes the item once the output register
// is free. Each entry is pushed once and popped at most once, and a new item is taken
// only after the last one is pushed. A two-entry input queue and an output register
// let the input and output sides stall independently. A full stack drops its oldest
// entry and sets overflow. No clearing pass is needed after reset.
module stock_span_monotonic_stack_top import ssms_pkg::*; #(
	parameter  int STACK_DEPTH    = 256,
	parameter  int HEIGHT_BITS    = 16,
	parameter  int SPAN_BITS      = 16,
	localparam int IN_TDATA_BITS  = ((HEIGHT_BITS + 7) / 8) * 8,
	localparam int OUT_TDATA_BITS = ((SPAN_BITS + 7) / 8) * 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,   // height, zero fill
	input  logic [0:0]                s_axis_tuser,   // first
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,   // span, zero fill
	output logic [0:0]                m_axis_tuser    // overflow
);

	ssms_item_ctrl_t        q_ctrl;
	logic [HEIGHT_BITS-1:0] q_height;
	logic                   q_ready;
	logic [SPAN_BITS-1:0]   m_span;
	logic                   m_overflow;

	ssms_front #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_first  (s_axis_tuser[0]),
		.in_height (s_axis_tdata[HEIGHT_BITS-1:0]),
		.q_ctrl    (q_ctrl),
		.q_height  (q_height),
		.q_ready   (q_ready)
	);

	ssms_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.HEIGHT_BITS (HEIGHT_BITS),
		.SPAN_BITS   (SPAN_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_ctrl     (q_ctrl),
		.q_height   (q_height),
		.q_ready    (q_ready),
		.m_valid    (m_axis_tvalid),
		.m_ready    (m_axis_tready),
		.m_span     (m_span),
		.m_overflow (m_overflow)
	);

	assign m_axis_tdata    = OUT_TDATA_BITS'(m_span);
	assign m_axis_tuser[0] = m_overflow;

endmodule
